// ===== hw/rtl/adaptive_rice_residual_coder_assert.svh =====
// Assertion macros used by the adaptive Rice coder top-level RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ADAPTIVE_RICE_RESIDUAL_CODER_ASSERT_SVH
`define ADAPTIVE_RICE_RESIDUAL_CODER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define ARRC_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define ARRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/arrc_pkg.sv =====
// Shared types, constants and helper functions of the adaptive Rice coder.
// No dependencies; every RTL module imports this package.
`default_nettype none

package arrc_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam int RESIDUAL_W = 32;
	localparam int CHANNEL_W = 3;
	localparam int PARAM_W = 5;
	localparam int SUM_W = 32;
	localparam int ONES_W = 33;
	localparam int REM_W = 31;

	localparam logic [PARAM_W-1:0] INIT_PARAM = 5'd10;
	localparam logic [PARAM_W-1:0] PARAM_MAX = 5'd31;
	localparam logic [SUM_W-1:0] INIT_SUM = 32'd16384;
	localparam int SUM_SHIFT = 4;

	typedef struct packed {
		logic [PARAM_W-1:0] param;
		logic [SUM_W-1:0] sum;
	} level_t;

	typedef struct packed {
		level_t first;
		level_t second;
	} chan_state_t;

	localparam chan_state_t INIT_STATE = '{
		first: '{param: INIT_PARAM, sum: INIT_SUM},
		second: '{param: INIT_PARAM, sum: INIT_SUM}
	};

	// 16 << k, saturated at 2^31
	function automatic logic [SUM_W-1:0] bound16(input logic [PARAM_W:0] k);
		logic [SUM_W-1:0] b;
		if (k >= 6'd27) begin
			b = 32'h8000_0000;
		end else begin
			b = 32'd16 << k;
		end
		return b;
	endfunction

	// signed residual to unsigned value, mod 2^32
	function automatic logic [SUM_W-1:0] zigzag(input logic [RESIDUAL_W-1:0] raw);
		logic [SUM_W-1:0] v;
		if (raw != '0 && !raw[RESIDUAL_W-1]) begin
			v = (raw << 1) - 32'd1;
		end else begin
			v = (32'd0 - raw) << 1;
		end
		return v;
	endfunction

	// channel number folded onto the implemented channel count
	function automatic logic [CH_IDX_W-1:0] ch_index(input logic [CHANNEL_W-1:0] channel);
		logic [CH_IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < (1 << CHANNEL_W); i++) begin
			if (channel == CHANNEL_W'(i)) begin
				idx = CH_IDX_W'(i % MAX_CHANNELS);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/arrc_adapt.sv =====
// One level of Rice parameter adaptation: running sum update and k step.
// Depends on arrc_pkg.
`default_nettype none

module arrc_adapt
	import arrc_pkg::*;
(
	input  level_t cur,
	input  logic [SUM_W-1:0] x,
	output level_t nxt
);

	logic [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0] lower;
	logic [SUM_W-1:0] upper;

	always_comb begin
		sum_new = cur.sum + x - (cur.sum >> SUM_SHIFT);
		lower = bound16({1'b0, cur.param});
		upper = bound16({1'b0, cur.param} + 6'd1);
		nxt.sum = sum_new;
		nxt.param = cur.param;
		if (cur.param != '0 && sum_new < lower) begin
			nxt.param = cur.param - 5'd1;
		end else if (cur.param < PARAM_MAX && sum_new > upper) begin
			nxt.param = cur.param + 5'd1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/arrc_state.sv =====
// Per-channel Rice state registers with a frame-wide return to initial values.
// Depends on arrc_pkg.
`default_nettype none

module arrc_state
	import arrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [CH_IDX_W-1:0] rd_idx,
	output chan_state_t rd_data,
	input  logic wr_en,
	input  logic wr_clear,
	input  logic [CH_IDX_W-1:0] wr_idx,
	input  chan_state_t wr_data
);

	chan_state_t state_q [MAX_CHANNELS];

	assign rd_data = state_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				state_q[i] <= INIT_STATE;
			end
		end else if (wr_en) begin
			// frame start: every other channel goes back to its initial state
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				if (wr_idx == CH_IDX_W'(i)) begin
					state_q[i] <= wr_data;
				end else if (wr_clear) begin
					state_q[i] <= INIT_STATE;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/adaptive_rice_residual_coder.sv =====
// Adaptive two-level Rice coder: an accepted word waits in the input register,
// then its result word goes to the output register; throughput one word per
// cycle while code_stall does not hold the output, set by the per-channel state
// read, adapt and write-back done combinationally. Reset (arst_n low) empties
// both registers and puts every channel at k=10, sum=16384.
`default_nettype none
`include "adaptive_rice_residual_coder_assert.svh"

module adaptive_rice_residual_coder
	import arrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [RESIDUAL_W-1:0] residual,
	input  logic [CHANNEL_W-1:0] channel,
	input  logic frame_start,
	output logic code_valid,
	input  logic code_stall,
	output logic [ONES_W-1:0] ones_count,
	output logic [REM_W-1:0] remainder,
	output logic [PARAM_W-1:0] remainder_len
);

	logic valid_s1;
	logic [RESIDUAL_W-1:0] residual_s1;
	logic [CH_IDX_W-1:0] chan_s1;
	logic frame_start_s1;

	logic code_valid_q;
	logic [ONES_W-1:0] ones_q;
	logic [REM_W-1:0] rem_q;
	logic [PARAM_W-1:0] len_q;

	logic take;
	logic move;

	chan_state_t rd_state;
	chan_state_t cur_state;
	chan_state_t wr_state;
	level_t first_nxt;
	level_t second_nxt;

	logic [SUM_W-1:0] val;
	logic [SUM_W-1:0] first_span;
	logic [SUM_W-1:0] reduced;
	logic escape;
	logic [PARAM_W-1:0] k_used;
	logic [SUM_W-1:0] coded;
	logic [SUM_W-1:0] rem_mask;
	logic [ONES_W-1:0] ones_d;
	logic [REM_W-1:0] rem_d;

	assign take = sample_valid && !sample_stall;
	assign move = valid_s1 && (!code_valid_q || !code_stall);
	assign sample_stall = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			residual_s1 <= residual;
			chan_s1 <= ch_index(channel);
			frame_start_s1 <= frame_start;
		end
	end

	arrc_state u_state (
		.clk(clk),
		.arst_n(arst_n),
		.rd_idx(chan_s1),
		.rd_data(rd_state),
		.wr_en(move),
		.wr_clear(frame_start_s1),
		.wr_idx(chan_s1),
		.wr_data(wr_state)
	);

	assign cur_state = frame_start_s1 ? INIT_STATE : rd_state;

	always_comb begin
		val = zigzag(residual_s1);
		first_span = 32'd1 << cur_state.first.param;
		escape = (val >= first_span);
		reduced = val - first_span;
	end

	arrc_adapt u_adapt_first (
		.cur(cur_state.first),
		.x(val),
		.nxt(first_nxt)
	);

	arrc_adapt u_adapt_second (
		.cur(cur_state.second),
		.x(reduced),
		.nxt(second_nxt)
	);

	always_comb begin
		wr_state.first = first_nxt;
		wr_state.second = escape ? second_nxt : cur_state.second;

		k_used = escape ? cur_state.second.param : cur_state.first.param;
		coded = escape ? reduced : val;
		rem_mask = (32'd1 << k_used) - 32'd1;
		rem_d = REM_W'(coded & rem_mask);
		if (escape) begin
			ones_d = ONES_W'(1) + ONES_W'(reduced >> cur_state.second.param);
		end else begin
			ones_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (move) begin
			code_valid_q <= 1'b1;
		end else if (!code_stall) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			ones_q <= ones_d;
			rem_q <= rem_d;
			len_q <= k_used;
		end
	end

	assign code_valid = code_valid_q;
	assign ones_count = ones_q;
	assign remainder = rem_q;
	assign remainder_len = len_q;

	`ARRC_ASSERT_HOLDS(a_rem_fits_len, code_valid_q,
		((SUM_W'(rem_q) >> len_q) == '0), "remainder wider than its length")
	`ARRC_ASSERT_HOLDS(a_stall_only_when_full, sample_stall, valid_s1,
		"input stalled with an empty input register")
	`ARRC_ASSERT_NEXT(a_move_fills_output, move, code_valid_q,
		"word left the input register but no result was shown")
	`ARRC_ASSERT_HOLDS(a_escape_has_ones, move && escape, (ones_d != '0),
		"escaped value coded without unary ones")

endmodule

`default_nettype wire

// ===== dv/tb_adaptive_rice_residual_coder.sv =====
// Self-checking bench for adaptive_rice_residual_coder: drives residual words with
// random gaps and stalls, predicts each code word from per-channel Rice state.
// Depends on arrc_pkg and the coder RTL only.
`timescale 1ns / 100ps

module tb_adaptive_rice_residual_coder;
	import arrc_pkg::*;

	typedef struct {
		logic [RESIDUAL_W-1:0] residual;
		logic [CHANNEL_W-1:0] channel;
		logic frame_start;
	} sample_word_t;

	typedef struct {
		logic [ONES_W-1:0] ones;
		logic [REM_W-1:0] rem;
		logic [PARAM_W-1:0] len;
	} code_word_t;

	typedef enum int {
		RUN_QUIET,
		RUN_LOUD,
		RUN_SCALED,
		RUN_FULL,
		RUN_MIXED
	} run_kind_e;

	localparam int PHASE_ITEMS = 375;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [RESIDUAL_W-1:0] residual = '0;
	logic [CHANNEL_W-1:0] channel = '0;
	logic frame_start = 1'b0;
	logic code_valid;
	logic code_stall = 1'b0;
	logic [ONES_W-1:0] ones_count;
	logic [REM_W-1:0] remainder;
	logic [PARAM_W-1:0] remainder_len;

	sample_word_t pending_words[$];
	code_word_t expected_codes[$];
	logic word_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned words_queued = 0;
	int unsigned codes_seen = 0;
	bit failed = 1'b0;

	// per-channel Rice state as predicted
	logic [PARAM_W-1:0] lvl1_k[MAX_CHANNELS];
	logic [PARAM_W-1:0] lvl2_k[MAX_CHANNELS];
	logic [SUM_W-1:0] lvl1_sum[MAX_CHANNELS];
	logic [SUM_W-1:0] lvl2_sum[MAX_CHANNELS];

	adaptive_rice_residual_coder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.residual(residual),
		.channel(channel),
		.frame_start(frame_start),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.ones_count(ones_count),
		.remainder(remainder),
		.remainder_len(remainder_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_chans();
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			lvl1_k[i] = INIT_PARAM;
			lvl2_k[i] = INIT_PARAM;
			lvl1_sum[i] = INIT_SUM;
			lvl2_sum[i] = INIT_SUM;
		end
	endfunction

	// 16 << k, clamped at 2^31
	function automatic logic [SUM_W-1:0] step_bound(input int unsigned k);
		if (k >= 27) begin
			return 32'h8000_0000;
		end
		return 32'd16 << k;
	endfunction

	function automatic void adapt_level(inout logic [SUM_W-1:0] s, inout logic [PARAM_W-1:0] p,
			input logic [SUM_W-1:0] x);
		s = s + x - (s >> SUM_SHIFT);
		if (p > 0 && s < step_bound(p)) begin
			p = p - 1'b1;
		end else if (p < PARAM_MAX && s > step_bound(int'(p) + 1)) begin
			p = p + 1'b1;
		end
	endfunction

	function automatic code_word_t rice_code(input sample_word_t w);
		code_word_t c;
		logic [SUM_W-1:0] v;
		logic [PARAM_W-1:0] k;
		int unsigned ch;
		if (w.frame_start) begin
			reset_chans();
		end
		ch = int'(w.channel) % MAX_CHANNELS;
		if (w.residual != '0 && !w.residual[RESIDUAL_W-1]) begin
			v = (w.residual << 1) - 32'd1;
		end else begin
			v = (32'd0 - w.residual) << 1;
		end
		k = lvl1_k[ch];
		adapt_level(lvl1_sum[ch], lvl1_k[ch], v);
		c.ones = '0;
		if (v >= (32'd1 << k)) begin
			v = v - (32'd1 << k);
			k = lvl2_k[ch];
			adapt_level(lvl2_sum[ch], lvl2_k[ch], v);
			c.ones = ONES_W'(v >> k) + 1'b1;
		end
		c.len = k;
		c.rem = (k == 0) ? '0 : REM_W'(v & ((32'd1 << k) - 32'd1));
		return c;
	endfunction

	// present a new word once the previous one is taken
	always @(negedge clk) begin : driver
		sample_word_t w;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || word_taken) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				sample_valid <= 1'b1;
				residual <= w.residual;
				channel <= w.channel;
				frame_start <= w.frame_start;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		code_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : monitor
		code_word_t want;
		sample_word_t got;
		word_taken <= sample_valid && !sample_stall;
		if (arst_n) begin
			if (code_valid && !code_stall) begin
				codes_seen++;
				if (expected_codes.size() == 0) begin
					$error("code word with no expected result");
					failed = 1'b1;
				end else begin
					want = expected_codes.pop_front();
					if (ones_count !== want.ones) begin
						$error("ones_count: expected %0d, got %0d", want.ones, ones_count);
						failed = 1'b1;
					end
					if (remainder !== want.rem) begin
						$error("remainder: expected %0d, got %0d", want.rem, remainder);
						failed = 1'b1;
					end
					if (remainder_len !== want.len) begin
						$error("remainder_len: expected %0d, got %0d", want.len,
							remainder_len);
						failed = 1'b1;
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				got = '{residual, channel, frame_start};
				expected_codes.push_back(rice_code(got));
			end
		end
	end

	task automatic queue_word(input logic [RESIDUAL_W-1:0] r, input logic [CHANNEL_W-1:0] ch,
			input logic fs);
		pending_words.push_back('{r, ch, fs});
		words_queued++;
	endtask

	// a run of residuals of one kind, on one channel but for the mixed kind, so parameters drift far
	task automatic queue_run();
		run_kind_e kind;
		int unsigned len;
		logic [CHANNEL_W-1:0] ch;
		logic [RESIDUAL_W-1:0] r;
		logic fs;
		kind = run_kind_e'($urandom_range(RUN_MIXED));
		len = (kind == RUN_QUIET) ? $urandom_range(160, 40) : $urandom_range(60, 5);
		ch = $urandom_range(7);
		for (int i = 0; i < len; i++) begin
			fs = 1'b0;
			case (kind)
				RUN_QUIET: begin
					r = 32'($urandom_range(2)) - 32'd1;
				end
				RUN_LOUD: begin
					// magnitude near 2^26..2^27 pushes the first sum past 2^31
					r = 32'h0400_0000 | ($urandom & 32'h03ff_ffff);
					if ($urandom_range(1)) begin
						r = 32'd0 - r;
					end
				end
				RUN_SCALED: begin
					r = $signed($urandom) >>> $urandom_range(31);
					fs = ($urandom_range(49) == 0);
				end
				RUN_FULL: begin
					r = $urandom;
				end
				default: begin
					ch = $urandom_range(7);
					r = $signed($urandom) >>> $urandom_range(31);
					fs = ($urandom_range(49) == 0);
				end
			endcase
			queue_word(r, ch, fs);
		end
	endtask

	initial begin : stimulus
		int unsigned phase_end;
		reset_chans();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 56; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 56; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			if (ph == 0) begin
				queue_word(32'd0, 3'd0, 1'b1);
				queue_word(32'h7fff_ffff, 3'd0, 1'b0);
				queue_word(32'h8000_0000, 3'd0, 1'b0);
				queue_word(32'hffff_ffff, 3'd0, 1'b0);
				queue_word(32'd1, 3'd0, 1'b0);
				queue_word(32'd512, 3'd1, 1'b0);
				queue_word(32'd513, 3'd1, 1'b0);
				queue_word(32'd0 - 32'd512, 3'd1, 1'b0);
				queue_word(32'h8000_0000, 3'd7, 1'b0);
				queue_word(32'h7fff_ffff, 3'd7, 1'b0);
				for (int c = 2; c < 8; c++) begin
					queue_word($urandom, CHANNEL_W'(c), 1'b0);
				end
				queue_word(32'd5, 3'd7, 1'b1);
				queue_word(32'd0 - 32'd5, 3'd0, 1'b0);
			end
			phase_end = words_queued + PHASE_ITEMS;
			while (words_queued < phase_end) begin
				queue_run();
			end
			while (codes_seen < words_queued) begin
				@(negedge clk);
			end
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && expected_codes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/arrc_pkg.sv
hw/rtl/arrc_adapt.sv
hw/rtl/arrc_state.sv
hw/rtl/adaptive_rice_residual_coder.sv
dv/tb_adaptive_rice_residual_coder.sv
